/* hw/rtl/wkm_pkg.sv */
// Shared constants, types and state encodings of the weighted Kaplan-Meier block.
package wkm_pkg;

    localparam int MAX_ITEMS   = 64;
    localparam int WEIGHT_W    = 16;
    localparam int WEIGHT_BITS = 16;
    localparam int POS_W       = 6;
    localparam int IDX_W       = $clog2(MAX_ITEMS);
    localparam int CNT_W       = $clog2(MAX_ITEMS + 1);
    localparam int TOTAL_W     = WEIGHT_BITS + 6;
    localparam int Q_W         = 32;
    localparam int PROD_W      = Q_W + TOTAL_W;
    localparam int STEP_W      = $clog2(Q_W + 1);

    localparam logic [Q_W-1:0] ONE_Q31  = {1'b1, {(Q_W - 1){1'b0}}};
    localparam logic [Q_W-1:0] ZERO_Q31 = '0;

    typedef enum logic [2:0] {
        S_LOAD,
        S_READ,
        S_CALC,
        S_DIV,
        S_EMIT
    } t_state;

    typedef enum logic [1:0] {
        DV_IDLE,
        DV_MUL,
        DV_STEP
    } t_div_state;

    typedef struct packed {
        logic               start;
        logic [Q_W-1:0]     prev;
        logic [TOTAL_W-1:0] keep;
        logic [TOTAL_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic           done;
        logic [Q_W-1:0] quot;
    } t_div_rsp;

endpackage

/* hw/rtl/wkm_if.sv */
// Valid/ready channel interfaces for observation requests and result requests.
interface wkm_obs_if import wkm_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                event_req;
    logic [WEIGHT_W-1:0] weight;
    logic                last_item;

    modport source (output valid, output event_req, output weight, output last_item,
                    input ready);
    modport sink   (input valid, input event_req, input weight, input last_item,
                    output ready);
endinterface

interface wkm_res_if import wkm_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [POS_W-1:0] position;
    logic [Q_W-1:0]   survival;
    logic [Q_W-1:0]   jump;
    logic             zero_weight_error;
    logic             overflow;
    logic             last_result;

    modport source (output valid, output position, output survival, output jump,
                    output zero_weight_error, output overflow, output last_result,
                    input ready);
    modport sink   (input valid, input position, input survival, input jump,
                    input zero_weight_error, input overflow, input last_result,
                    output ready);
endinterface

/* hw/rtl/wkm_div.sv */
// Scaling unit: floor(prev * keep / divisor) by one multiply and a bit-serial divide.
module wkm_div import wkm_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    t_div_state         r_state, n_state;
    logic [PROD_W-1:0]  r_prod,  n_prod;
    logic [TOTAL_W-1:0] r_rem,   n_rem;
    logic [TOTAL_W-1:0] r_div,   n_div;
    logic [Q_W-1:0]     r_q,     n_q;
    logic [STEP_W-1:0]  r_cnt,   n_cnt;
    logic               r_done,  n_done;

    logic [TOTAL_W:0]   trial;
    logic [TOTAL_W:0]   diff;
    logic               fits;

    // The remainder stays below the divisor, so one compare and subtract per bit suffices.
    assign trial = {r_rem, r_q[Q_W-1]};
    assign diff  = trial - {1'b0, r_div};
    assign fits  = (trial >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= DV_IDLE;
            r_done  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
        r_rem  <= n_rem;
        r_div  <= n_div;
        r_q    <= n_q;
    end

    always_comb begin
        n_state = r_state;
        n_prod  = r_prod;
        n_rem   = r_rem;
        n_div   = r_div;
        n_q     = r_q;
        n_cnt   = r_cnt;
        n_done  = 1'b0;
        case (r_state)
            DV_IDLE: begin
                if (i_req.start) begin
                    n_prod  = PROD_W'(i_req.prev) * PROD_W'(i_req.keep);
                    n_div   = i_req.divisor;
                    n_state = DV_MUL;
                end
            end
            DV_MUL: begin
                // The upper product bits are below the divisor since prev < 2^32.
                n_rem   = r_prod[PROD_W-1:Q_W];
                n_q     = r_prod[Q_W-1:0];
                n_cnt   = STEP_W'(Q_W);
                n_state = DV_STEP;
            end
            DV_STEP: begin
                n_rem = fits ? diff[TOTAL_W-1:0] : trial[TOTAL_W-1:0];
                n_q   = {r_q[Q_W-2:0], fits};
                n_cnt = r_cnt - STEP_W'(1);
                if (r_cnt == STEP_W'(1)) begin
                    n_done  = 1'b1;
                    n_state = DV_IDLE;
                end
            end
            default: begin
                n_state = DV_IDLE;
            end
        endcase
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_q;

endmodule

/* hw/rtl/weighted_kaplan_meier.sv */
// Top level of the weighted Kaplan-Meier survival estimator.
//
// Observation requests arrive sorted by time, one per accepted request, each with an
// event flag and a weight; up to 64 are stored in an on-chip memory and their weights
// are summed, and any beyond that are dropped and reported through the overflow flag
// on every result of the run. The request marked last starts the walk: the block stops
// taking observations and emits one result request per stored item, in order, with the
// survival after that point and its jump, both unsigned Q1.31 (2^31 is 1.0). The
// remaining weight starts at the total and drops by the previous item's weight at each
// step; an event scales the survival by (remaining - weight) / remaining, rounded down,
// while a censored item, or an event met with zero remaining weight (flagged as an
// error), leaves it unchanged. While loading, ready stays high. During the walk each
// item passes a read, a calculation and an emit state, waiting in the emit state while
// the result sink holds ready low; an event met with nonzero remaining weight also waits
// in a divide state for the shared scaling unit, which does one 32 by 22 bit multiply
// and then a 32-step restoring division, one quotient bit per cycle. After the last
// result the run state clears and the block takes the next run's observations at once.
module weighted_kaplan_meier import wkm_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    wkm_obs_if.sink   i_obs,
    wkm_res_if.source o_res
);

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [TOTAL_W-1:0] r_total, n_total;
    logic               r_ovf,   n_ovf;
    logic [CNT_W-1:0]   r_n,     n_n;
    logic [IDX_W-1:0]   r_idx,   n_idx;
    logic [TOTAL_W-1:0] r_rem,   n_rem;
    logic [WEIGHT_BITS-1:0] r_wprev, n_wprev;
    logic [Q_W-1:0]     r_surv,  n_surv;
    logic [Q_W-1:0]     r_jump,  n_jump;
    logic               r_err,   n_err;

    // Item store: event flag in the top bit, weight below.
    logic [WEIGHT_BITS:0] mem [MAX_ITEMS];
    logic [WEIGHT_BITS:0] r_rd;

    logic                   accept;
    logic                   store_ok;
    logic [WEIGHT_BITS-1:0] w_in;
    logic                   rd_event;
    logic [WEIGHT_BITS-1:0] rd_w;
    logic [TOTAL_W-1:0]     rem_now;
    logic [TOTAL_W-1:0]     keep;
    logic                   last_pos;
    t_div_req               div_req;
    t_div_rsp               div_rsp;

    assign i_obs.ready = (r_state == S_LOAD);
    assign accept      = i_obs.valid && i_obs.ready;
    assign store_ok    = (r_count < CNT_W'(MAX_ITEMS));
    assign w_in        = i_obs.weight[WEIGHT_BITS-1:0];

    assign rd_event = r_rd[WEIGHT_BITS];
    assign rd_w     = r_rd[WEIGHT_BITS-1:0];

    // Remaining weight at this item: the running value less the previous item's weight.
    assign rem_now = (r_rem >= TOTAL_W'(r_wprev)) ? (r_rem - TOTAL_W'(r_wprev)) : '0;
    assign keep    = (rem_now >= TOTAL_W'(rd_w)) ? (rem_now - TOTAL_W'(rd_w)) : '0;

    assign last_pos = ((CNT_W'(r_idx) + CNT_W'(1)) == r_n);

    assign div_req.start   = (r_state == S_CALC) && rd_event && (rem_now != '0);
    assign div_req.prev    = r_surv;
    assign div_req.keep    = keep;
    assign div_req.divisor = rem_now;

    wkm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (accept && store_ok) begin
            mem[r_count[IDX_W-1:0]] <= {i_obs.event_req, w_in};
        end
        r_rd <= mem[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_count <= '0;
            r_total <= '0;
            r_ovf   <= 1'b0;
            r_n     <= '0;
            r_idx   <= '0;
            r_rem   <= '0;
            r_wprev <= '0;
            r_surv  <= ONE_Q31;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_total <= n_total;
            r_ovf   <= n_ovf;
            r_n     <= n_n;
            r_idx   <= n_idx;
            r_rem   <= n_rem;
            r_wprev <= n_wprev;
            r_surv  <= n_surv;
        end
    end

    always_ff @(posedge i_clk) begin
        r_jump <= n_jump;
        r_err  <= n_err;
    end

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_total = r_total;
        n_ovf   = r_ovf;
        n_n     = r_n;
        n_idx   = r_idx;
        n_rem   = r_rem;
        n_wprev = r_wprev;
        n_surv  = r_surv;
        n_jump  = r_jump;
        n_err   = r_err;
        case (r_state)
            S_LOAD: begin
                if (accept) begin
                    if (store_ok) begin
                        n_count = r_count + CNT_W'(1);
                        n_total = r_total + TOTAL_W'(w_in);
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_obs.last_item) begin
                        // A dropped item marked last still starts the walk.
                        n_n     = n_count;
                        n_idx   = '0;
                        n_rem   = n_total;
                        n_wprev = '0;
                        n_surv  = ONE_Q31;
                        n_state = S_READ;
                    end
                end
            end
            S_READ: begin
                n_state = S_CALC;
            end
            S_CALC: begin
                n_rem   = rem_now;
                n_wprev = rd_w;
                if (div_req.start) begin
                    n_state = S_DIV;
                end else begin
                    n_jump  = ZERO_Q31;
                    n_err   = rd_event;
                    n_state = S_EMIT;
                end
            end
            S_DIV: begin
                if (div_rsp.done) begin
                    n_surv  = div_rsp.quot;
                    n_jump  = r_surv - div_rsp.quot;
                    n_err   = 1'b0;
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (o_res.ready) begin
                    if (last_pos) begin
                        n_count = '0;
                        n_total = '0;
                        n_ovf   = 1'b0;
                        n_surv  = ONE_Q31;
                        n_state = S_LOAD;
                    end else begin
                        n_idx   = r_idx + IDX_W'(1);
                        n_state = S_READ;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    assign o_res.valid             = (r_state == S_EMIT);
    assign o_res.position          = POS_W'(r_idx);
    assign o_res.survival          = r_surv;
    assign o_res.jump              = r_jump;
    assign o_res.zero_weight_error = r_err;
    assign o_res.overflow          = r_ovf;
    assign o_res.last_result       = last_pos;

    // The block never takes an observation while a result is on offer.
    a_no_load_in_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_res.valid && i_obs.ready))
        else $error("observation accepted during the walk");

    // The store never counts more items than it holds.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_ITEMS))
        else $error("item count beyond capacity");

    // A scaling result only arrives while the sequencer waits for it.
    a_div_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> (r_state == S_DIV))
        else $error("scaling unit finished outside its wait state");

    // Survival never exceeds one, and survival plus its jump never exceeds one either.
    a_surv_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> ((r_surv <= ONE_Q31) && ((r_surv + r_jump) <= ONE_Q31)))
        else $error("survival or jump out of range");

endmodule

/* verif/wkm_checker.sv */
// Scoreboard for the weighted Kaplan-Meier block: predicts each run's results and compares them.
module wkm_checker import wkm_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    wkm_obs_if   i_obs,
    wkm_res_if   i_res,
    output int   o_fail_count,
    output int   o_pending
);

    typedef struct packed {
        logic [POS_W-1:0] position;
        logic [Q_W-1:0]   survival;
        logic [Q_W-1:0]   jump;
        logic             zero_weight_error;
        logic             overflow;
        logic             last_result;
    } t_km_point;

    // Observations of the run being loaded.
    logic                is_event_mem [MAX_ITEMS];
    logic [WEIGHT_W-1:0] weight_mem   [MAX_ITEMS];
    int                  stored_count;
    logic [TOTAL_W-1:0]  weight_sum;
    logic                dropped_seen;

    t_km_point survival_due [$];

    task automatic report(input string msg);
        $display("[%0t] check failed: %s", $time, msg);
        o_fail_count++;
    endtask

    task automatic clear_run();
        stored_count = 0;
        weight_sum   = '0;
        dropped_seen = 1'b0;
    endtask

    // Walks the stored observations and queues the survival curve they produce.
    task automatic predict_survival_walk();
        logic [TOTAL_W-1:0] at_risk;
        logic [TOTAL_W-1:0] kept;
        longint unsigned    surv;
        longint unsigned    next_surv;
        t_km_point          point;
        at_risk = weight_sum;
        surv    = ONE_Q31;
        for (int k = 0; k < stored_count; k++) begin
            if (k > 0)
                at_risk = (at_risk >= weight_mem[k-1]) ? at_risk - weight_mem[k-1] : '0;
            point.jump              = ZERO_Q31;
            point.zero_weight_error = 1'b0;
            if (is_event_mem[k]) begin
                if (at_risk == '0) begin
                    point.zero_weight_error = 1'b1;
                end else begin
                    kept       = (at_risk >= weight_mem[k]) ? at_risk - weight_mem[k] : '0;
                    next_surv  = (surv * longint'(kept)) / longint'(at_risk);
                    point.jump = Q_W'(surv - next_surv);
                    surv       = next_surv;
                end
            end
            point.position    = POS_W'(k);
            point.survival    = Q_W'(surv);
            point.overflow    = dropped_seen;
            point.last_result = (k == stored_count - 1);
            survival_due.push_back(point);
        end
        clear_run();
    endtask

    task automatic take_observation();
        if (stored_count < MAX_ITEMS) begin
            is_event_mem[stored_count] = i_obs.event_req;
            weight_mem[stored_count]   = i_obs.weight;
            weight_sum                 = weight_sum + TOTAL_W'(i_obs.weight);
            stored_count++;
        end else begin
            dropped_seen = 1'b1;
        end
        if (i_obs.last_item)
            predict_survival_walk();
    endtask

    task automatic check_result();
        t_km_point got;
        t_km_point want;
        got = '{i_res.position, i_res.survival, i_res.jump, i_res.zero_weight_error,
                i_res.overflow, i_res.last_result};
        if (survival_due.size() == 0) begin
            report($sformatf("result at position %0d with none outstanding", got.position));
            return;
        end
        want = survival_due.pop_front();
        if (got.position !== want.position)
            report($sformatf("position got %0d want %0d", got.position, want.position));
        if (got.survival !== want.survival)
            report($sformatf("survival at %0d got %h want %h",
                             want.position, got.survival, want.survival));
        if (got.jump !== want.jump)
            report($sformatf("jump at %0d got %h want %h",
                             want.position, got.jump, want.jump));
        if (got.zero_weight_error !== want.zero_weight_error)
            report($sformatf("zero_weight_error at %0d got %b want %b",
                             want.position, got.zero_weight_error, want.zero_weight_error));
        if (got.overflow !== want.overflow)
            report($sformatf("overflow at %0d got %b want %b",
                             want.position, got.overflow, want.overflow));
        if (got.last_result !== want.last_result)
            report($sformatf("last_result at %0d got %b want %b",
                             want.position, got.last_result, want.last_result));
    endtask

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        clear_run();
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_run();
            survival_due.delete();
        end else begin
            if (i_res.valid === 1'b1 && i_res.ready === 1'b1)
                check_result();
            if (i_obs.valid === 1'b1 && i_obs.ready === 1'b1)
                take_observation();
        end
        o_pending = survival_due.size();
    end

endmodule

/* verif/tb.sv */
// Testbench top: drives observation runs into the Kaplan-Meier block and gives the verdict.
//
// Observation requests are sent in runs, each closed by a request marked last.
// The checker beside the block sees every accepted request on both channels,
// predicts the survival curve of each run and compares the result requests
// with it field by field. This module only makes stimulus and decides the
// outcome from the checker's failure count.
module tb;
    import wkm_pkg::*;

    localparam int RANDOM_ITEMS = 410;

    // Kinds of weight mix used for a random run.
    typedef enum int {
        W_FULL,
        W_SMALL,
        W_EXTREME,
        W_MIXED
    } t_weight_mix;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    wkm_obs_if obs_ch ();
    wkm_res_if res_ch ();

    int fail_count;
    int pending;
    int sent_count = 0;

    // When set, the sender or the receiver runs without any idle cycles.
    logic tx_calm = 1'b0;
    logic rx_calm = 1'b0;

    weighted_kaplan_meier dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_obs   (obs_ch),
        .o_res   (res_ch)
    );

    wkm_checker chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_obs        (obs_ch),
        .i_res        (res_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Sends one observation request. It is entered and left at a falling edge,
    // so that valid is changed at most once per time step.
    task automatic send_obs(input logic ev, input logic [WEIGHT_W-1:0] w, input logic last);
        int gap;
        gap = tx_calm ? 0 : $urandom_range(0, 17);
        if (gap > 0) begin
            obs_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        obs_ch.valid     <= 1'b1;
        obs_ch.event_req <= ev;
        obs_ch.weight    <= w;
        obs_ch.last_item <= last;
        do @(posedge i_clk); while (obs_ch.ready !== 1'b1);
        @(negedge i_clk);
        sent_count++;
    endtask

    // Holds the sender off until every predicted result has been taken.
    task automatic drain_results();
        obs_ch.valid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
    endtask

    function automatic logic [WEIGHT_W-1:0] draw_weight(input t_weight_mix mix);
        logic [WEIGHT_W-1:0] w;
        case (mix)
            W_FULL: begin
                w = WEIGHT_W'($urandom_range(0, 65535));
            end
            W_SMALL: begin
                w = WEIGHT_W'($urandom_range(0, 7));
            end
            W_EXTREME: begin
                case ($urandom_range(0, 3))
                    0:       w = '0;
                    1:       w = WEIGHT_W'(1);
                    2:       w = '1;
                    default: w = {{(WEIGHT_W - 1){1'b1}}, 1'b0};
                endcase
            end
            default: begin
                w = draw_weight(t_weight_mix'($urandom_range(0, 2)));
            end
        endcase
        return w;
    endfunction

    // One run with random content. Some runs end in zero-weight items so that
    // events meet an empty risk set; the event density ranges from all
    // censored to all events.
    task automatic random_run(input int len);
        t_weight_mix         mix;
        int                  event_rate;
        int                  zero_tail;
        logic                ev;
        logic [WEIGHT_W-1:0] w;
        mix        = t_weight_mix'($urandom_range(0, 3));
        event_rate = $urandom_range(0, 4);
        zero_tail  = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0;
        tx_calm    = ($urandom_range(0, 3) == 0);
        rx_calm    = ($urandom_range(0, 3) == 0);
        for (int k = 0; k < len; k++) begin
            ev = ($urandom_range(0, 3) < event_rate);
            w  = (k >= len - zero_tail) ? '0 : draw_weight(mix);
            send_obs(ev, w, k == len - 1);
        end
    endtask

    // Result side: per result, ready is held low for a random number of
    // cycles, then kept high until the block hands a result over.
    initial begin
        int stall;
        res_ch.ready = 1'b0;
        @(negedge i_clk);
        forever begin
            stall = rx_calm ? 0 : $urandom_range(0, 17);
            if (stall > 0) begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            res_ch.ready <= 1'b1;
            do @(posedge i_clk); while (res_ch.valid !== 1'b1);
            @(negedge i_clk);
        end
    end

    initial begin
        int random_base;
        int run_no;
        int len;
        obs_ch.valid     = 1'b0;
        obs_ch.event_req = 1'b0;
        obs_ch.weight    = '0;
        obs_ch.last_item = 1'b0;

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // A single event of full weight empties the curve: survival falls
        // from one to zero in one step.
        send_obs(1'b1, '1, 1'b1);

        // The total weight is zero, so a censored item and then an event
        // both meet an empty risk set; only the event is an error.
        send_obs(1'b0, '0, 1'b0);
        send_obs(1'b1, '0, 1'b1);

        // An event of zero weight leaves the curve alone, a tiny event
        // barely moves it, and the final event takes all that remains.
        send_obs(1'b1, '0, 1'b0);
        send_obs(1'b1, WEIGHT_W'(1), 1'b0);
        send_obs(1'b0, '1, 1'b0);
        send_obs(1'b1, '1, 1'b1);

        // Equal events: survival goes 3/4, 1/2, 1/4, 0 of one.
        tx_calm = 1'b1;
        rx_calm = 1'b1;
        repeat (3) send_obs(1'b1, WEIGHT_W'(3), 1'b0);
        send_obs(1'b1, WEIGHT_W'(3), 1'b1);

        // The risk set is exhausted before the last event, which is then
        // flagged after the curve has already moved.
        tx_calm = 1'b0;
        rx_calm = 1'b0;
        send_obs(1'b1, WEIGHT_W'(1), 1'b0);
        send_obs(1'b0, '0, 1'b0);
        send_obs(1'b1, '0, 1'b1);

        random_run(8);

        // Let the block finish every walk before the random part starts.
        drain_results();

        random_base = sent_count;
        run_no      = 0;
        while (sent_count - random_base < RANDOM_ITEMS) begin
            // Most runs are short; one fills the store exactly, and a few
            // go past it so that the dropped items are flagged.
            if (run_no == 2)
                len = MAX_ITEMS;
            else if (run_no == 5)
                len = $urandom_range(MAX_ITEMS + 1, MAX_ITEMS + 6);
            else if ($urandom_range(0, 19) == 0)
                len = $urandom_range(MAX_ITEMS + 1, MAX_ITEMS + 6);
            else if ($urandom_range(0, 9) == 0)
                len = $urandom_range(30, MAX_ITEMS);
            else
                len = $urandom_range(1, 10);
            random_run(len);
            if (run_no % 8 == 7)
                drain_results();
            run_no++;
        end

        obs_ch.valid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        repeat (50) @(negedge i_clk);

        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Far beyond the slowest correct run.
    initial begin
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/wkm_pkg.sv
hw/rtl/wkm_if.sv
hw/rtl/wkm_div.sv
hw/rtl/weighted_kaplan_meier.sv
verif/wkm_checker.sv
verif/tb.sv
